>>> design/ppts_pkg.sv
package ppts_pkg;

  localparam int MAX_TASKS = 15;
  localparam int SLOTS     = MAX_TASKS + 1;
  localparam int SLOT_W    = $clog2(SLOTS);

  localparam logic [7:0] IDLE_PRIORITY    = 8'd0;
  localparam logic [7:0] LOWEST_PRIORITY  = 8'd0;
  localparam logic [7:0] HIGHEST_PRIORITY = 8'd255;

  localparam logic [4:0] SLOTS_CNT = 5'(SLOTS);

  typedef enum logic [2:0] {
    KIND_INIT     = 3'd0,
    KIND_REGISTER = 3'd1,
    KIND_DELETE   = 3'd2,
    KIND_TICK     = 3'd3,
    KIND_FINISH   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOT_INIT = 3'd1,
    ST_ARG      = 3'd2,
    ST_HANDLE   = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DEL_CHK,
    S_DEL_MOVE,
    S_FIN_WR,
    S_TICK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [4:0]  stored_id;
    logic [15:0] period;
    logic [7:0]  priority_lvl;
    logic [15:0] countdown;
    logic        ready;
  } slot_t;

endpackage

>>> design/periodic_priority_task_scheduler.sv
// Periodic fixed-priority task scheduler.
// Input channel (in_valid/in_stall) carries one request: kind, period,
// priority_req, handle_id and finished. Every request gives exactly one
// result on the output channel (out_valid/out_stall): status, task_id and
// task_count after the request.
// Requests are handled one at a time; in_stall is high from acceptance
// until the result has been loaded into the output register.
// Init, register, rejected requests and finish reports with nothing to
// clear go from decode straight to the finish step; a finish report that
// clears a ready flag adds a write-back step; delete adds a handle check
// and, if it matches, a move of the last entry. A tick walks the slot
// table (a full table of 16 slots), a memory with one read and one write
// port, one slot a cycle through one shared countdown update and
// priority compare.
// A result waits in the output register while out_stall is high; the
// next request is taken once that register has been loaded.
// Reset (rst_n low, synchronous) empties the output register and leaves
// the block not initialized with the last selected slot at 0; slot
// contents are undefined until an init writes the idle task.
module periodic_priority_task_scheduler
  import ppts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_period,
  input  logic [7:0]  in_priority_req,
  input  logic [4:0]  in_handle_id,
  input  logic        in_finished,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [4:0]  out_task_id,
  output logic [4:0]  out_task_count
);

  state_t state_r, state_nxt;

  logic [2:0]  kind_r;
  logic [15:0] per_r;
  logic [7:0]  pri_r;
  logic [4:0]  hid_r;
  logic        fin_r;

  logic [4:0]        count_r, count_nxt;
  logic [SLOT_W-1:0] last_r, last_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [SLOT_W-1:0] best_r, best_nxt;
  logic [7:0]        best_pri_r, best_pri_nxt;
  status_t           status_r, status_nxt;
  logic [4:0]        tid_r, tid_nxt;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [4:0]  out_task_id_r;
  logic [4:0]  out_task_count_r;

  slot_t             mem [SLOTS];
  slot_t             rd_data_r;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  slot_t             mem_wdata;
  logic [SLOT_W-1:0] mem_raddr;

  slot_t             upd;
  logic [SLOT_W-1:0] sel_now;
  logic [7:0]        sel_pri_now;
  logic              in_accept;
  logic              out_load;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // Countdown update and priority compare for the slot read last cycle.
  always_comb begin
    upd = rd_data_r;
    if (rd_data_r.countdown == 16'd0) begin
      upd.ready     = 1'b1;
      upd.countdown = rd_data_r.period - 16'd1;
    end else begin
      upd.countdown = rd_data_r.countdown - 16'd1;
    end
    sel_now     = best_r;
    sel_pri_now = best_pri_r;
    if (idx_r == '0) begin
      sel_now     = '0;
      sel_pri_now = rd_data_r.priority_lvl;
    end else if (upd.ready && (rd_data_r.priority_lvl > best_pri_r)) begin
      sel_now     = idx_r;
      sel_pri_now = rd_data_r.priority_lvl;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    last_nxt     = last_r;
    idx_nxt      = idx_r;
    best_nxt     = best_r;
    best_pri_nxt = best_pri_r;
    status_nxt   = status_r;
    tid_nxt      = tid_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = rd_data_r;
    mem_raddr    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        status_nxt = ST_OK;
        tid_nxt    = '0;
        state_nxt  = S_FINISH;
        if (kind_r == KIND_INIT) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = '{stored_id: 5'd0, period: 16'd1, priority_lvl: IDLE_PRIORITY,
                        countdown: 16'd0, ready: 1'b0};
          count_nxt = 5'd1;
          last_nxt  = '0;
        end else if (kind_r > KIND_FINISH) begin
          status_nxt = ST_ARG;
        end else if (count_r == 5'd0) begin
          status_nxt = ST_NOT_INIT;
        end else begin
          case (kind_r)
            KIND_REGISTER: begin
              if ((per_r == 16'd0) || (pri_r < LOWEST_PRIORITY) ||
                  (pri_r <= IDLE_PRIORITY) || (pri_r > HIGHEST_PRIORITY)) begin
                status_nxt = ST_ARG;
              end else if (count_r >= SLOTS_CNT) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[SLOT_W-1:0];
                mem_wdata = '{stored_id: count_r, period: per_r, priority_lvl: pri_r,
                              countdown: 16'd0, ready: 1'b0};
                tid_nxt   = count_r;
                count_nxt = count_r + 5'd1;
              end
            end
            KIND_DELETE: begin
              if (hid_r >= count_r) begin
                status_nxt = ST_HANDLE;
              end else begin
                mem_raddr = hid_r[SLOT_W-1:0];
                state_nxt = S_DEL_CHK;
              end
            end
            KIND_TICK: begin
              mem_raddr = '0;
              idx_nxt   = '0;
              state_nxt = S_TICK;
            end
            default: begin
              // finish report
              tid_nxt = 5'(last_r);
              if (fin_r && (5'(last_r) < count_r)) begin
                mem_raddr = last_r;
                state_nxt = S_FIN_WR;
              end
            end
          endcase
        end
      end

      S_DEL_CHK: begin
        if (rd_data_r.stored_id != hid_r) begin
          status_nxt = ST_HANDLE;
          state_nxt  = S_FINISH;
        end else begin
          // fetch the last entry to move into the freed slot
          mem_raddr = SLOT_W'(count_r - 5'd1);
          state_nxt = S_DEL_MOVE;
        end
      end

      S_DEL_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = hid_r[SLOT_W-1:0];
        mem_wdata = rd_data_r;
        count_nxt = count_r - 5'd1;
        state_nxt = S_FINISH;
      end

      S_FIN_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = last_r;
        mem_wdata       = rd_data_r;
        mem_wdata.ready = 1'b0;
        state_nxt       = S_FINISH;
      end

      S_TICK: begin
        mem_we       = 1'b1;
        mem_waddr    = idx_r;
        mem_wdata    = upd;
        best_nxt     = sel_now;
        best_pri_nxt = sel_pri_now;
        if ((5'(idx_r) + 5'd1) < count_r) begin
          idx_nxt   = idx_r + 1'b1;
          mem_raddr = idx_r + 1'b1;
        end else begin
          last_nxt  = sel_now;
          tid_nxt   = 5'(sel_now);
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= 5'd0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    best_r     <= best_nxt;
    best_pri_r <= best_pri_nxt;
    status_r   <= status_nxt;
    tid_r      <= tid_nxt;
    if (in_accept) begin
      kind_r <= in_kind;
      per_r  <= in_period;
      pri_r  <= in_priority_req;
      hid_r  <= in_handle_id;
      fin_r  <= in_finished;
    end
  end

  // Hold the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FINISH && out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FINISH && out_load) begin
      out_status_r     <= status_r;
      out_task_id_r    <= tid_r;
      out_task_count_r <= count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_task_id    = out_task_id_r;
  assign out_task_count = out_task_count_r;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= SLOTS_CNT)
    else $error("task count beyond table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != S_IDLE))
    else $error("accepted request not taken into processing");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result raised outside the finish step");

  a_tick_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK) |-> (5'(idx_r) < count_r))
    else $error("tick walk beyond the last task");
`endif

endmodule
